// ===== rtl/core/rmst_pkg.sv =====
// Shared constants and types for the range-maximum segment tree.
`default_nettype none

package rmst_pkg;

   localparam int LEAVES      = 1024;
   localparam int LEAF_BITS   = 10;
   localparam int NODE_BITS   = LEAF_BITS + 1;
   localparam int NODE_COUNT  = 2 * LEAVES;
   localparam int VALUE_BITS  = 32;
   localparam int OUT_BITS    = 32;
   localparam int REQ_BITS    = 64;
   localparam int REQ_PAD     = REQ_BITS - (3 * LEAF_BITS + VALUE_BITS);
   // one bit more than a node index so a bound one past the last node fits
   localparam int BOUND_BITS  = NODE_BITS + 1;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [REQ_PAD-1:0]    pad;
      logic [LEAF_BITS-1:0]  range_high;
      logic [LEAF_BITS-1:0]  range_low;
      logic [VALUE_BITS-1:0] new_value;
      logic [LEAF_BITS-1:0]  leaf_index;
   } req_data_type;

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_UPD_WR  = 7'b0000100,
      ST_UPD_MAX = 7'b0001000,
      ST_QRY_L   = 7'b0010000,
      ST_QRY_R   = 7'b0100000,
      ST_QRY_OUT = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/range_max_segment_tree_top.sv =====
// Range-maximum segment tree: one node memory with update and query sequencer.
//
// Requests enter on req_* (tvalid/tready). req_tuser selects the kind: 0 sets
// one leaf, 1 asks for the maximum over an inclusive leaf range. Updates give
// no response; each query gives one response on rsp_* holding the maximum,
// or 0 for an empty range.
// All tree nodes sit in one 2048 x 32 synchronous memory (one read, one
// write port, registered read data). An update writes the leaf, then per
// level reads the sibling and writes the parent, up to the root. A query
// walks both range ends up the tree, one read per end per level, folding
// each read into the running maximum until the ends meet, and then loads
// the output register; an empty range goes straight to that last step.
// The next request is taken once the sequencer is back in idle.
// One request is worked on at a time; req_tready is high only when the
// sequencer is idle. The response sits in an output register, so a new
// request is taken while an earlier response still waits for rsp_tready.
// A finished query waits until that register is free.
// After reset the block clears the memory one node per cycle, with
// req_tready low.
`default_nettype none

module range_max_segment_tree_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [9:0] leaf_index, [41:10] new_value, [51:42] range_low,
   // [61:52] range_high, [63:62] zero
   input  wire logic [rmst_pkg::REQ_BITS-1:0] req_tdata,
   // [0] kind
   input  wire logic                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [31:0] max_value
   output logic [rmst_pkg::OUT_BITS-1:0]     rsp_tdata
);
   import rmst_pkg::*;

   logic [VALUE_BITS-1:0] node_mem [NODE_COUNT];
   logic [VALUE_BITS-1:0] rdata_ff;

   state_type               state_ff, state_in;
   logic [NODE_BITS-1:0]    clr_ff, clr_in;
   logic [NODE_BITS-1:0]    pos_ff, pos_in;
   logic [VALUE_BITS-1:0]   cur_ff, cur_in;
   logic [BOUND_BITS-1:0]   left_ff, left_in;
   logic [BOUND_BITS-1:0]   right_ff, right_in;
   logic [VALUE_BITS-1:0]   best_ff, best_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]     rsp_data_ff, rsp_data_in;

   logic                    mem_we;
   logic [NODE_BITS-1:0]    mem_waddr;
   logic [VALUE_BITS-1:0]   mem_wdata;
   logic [NODE_BITS-1:0]    mem_raddr;

   req_data_type            req;
   logic                    req_fire;
   logic [VALUE_BITS-1:0]   best_fold;
   logic [BOUND_BITS-1:0]   right_dec;
   logic                    out_free;

   assign req        = req_data_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // fold in the node read issued in the previous cycle
   assign best_fold = (pend_ff && (rdata_ff > best_ff)) ? rdata_ff : best_ff;
   assign right_dec = right_ff - BOUND_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      best_in      = best_ff;
      pend_in      = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = cur_ff;
      mem_raddr    = pos_ff ^ NODE_BITS'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + NODE_BITS'(1);
            if (clr_ff == NODE_BITS'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_UPDATE) begin
                  pos_in   = NODE_BITS'(LEAVES) + NODE_BITS'(req.leaf_index);
                  cur_in   = req.new_value;
                  state_in = ST_UPD_WR;
               end else begin
                  best_in  = '0;
                  left_in  = BOUND_BITS'(LEAVES) + BOUND_BITS'(req.range_low);
                  right_in = BOUND_BITS'(LEAVES) + BOUND_BITS'(req.range_high)
                             + BOUND_BITS'(1);
                  if (req.range_low > req.range_high) begin
                     state_in = ST_QRY_OUT;
                  end else begin
                     state_in = ST_QRY_L;
                  end
               end
            end
         end
         ST_UPD_WR: begin
            // write this node, fetch its sibling for the parent
            mem_we = 1'b1;
            if (pos_ff == NODE_BITS'(1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_UPD_MAX;
            end
         end
         ST_UPD_MAX: begin
            cur_in   = (rdata_ff > cur_ff) ? rdata_ff : cur_ff;
            pos_in   = pos_ff >> 1;
            state_in = ST_UPD_WR;
         end
         ST_QRY_L: begin
            best_in = best_fold;
            if (left_ff < right_ff) begin
               if (left_ff[0]) begin
                  mem_raddr = left_ff[NODE_BITS-1:0];
                  pend_in   = 1'b1;
                  left_in   = left_ff + BOUND_BITS'(1);
               end
               state_in = ST_QRY_R;
            end else begin
               state_in = ST_QRY_OUT;
            end
         end
         ST_QRY_R: begin
            best_in = best_fold;
            left_in = left_ff >> 1;
            if (right_ff[0]) begin
               mem_raddr = right_dec[NODE_BITS-1:0];
               pend_in   = 1'b1;
               right_in  = right_dec >> 1;
            end else begin
               right_in  = right_ff >> 1;
            end
            state_in = ST_QRY_L;
         end
         ST_QRY_OUT: begin
            if (out_free) begin
               rsp_data_in  = OUT_BITS'(best_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= node_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== verif/tb_range_max_segment_tree_top.sv =====
// Testbench for range_max_segment_tree_top: directed table, then random updates and queries.
`timescale 1ns / 1ps

module tb_range_max_segment_tree_top;
   import rmst_pkg::*;

   localparam int IDLE_LIMIT    = 12000;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int TAIL_CYCLES   = 40;
   localparam int STALL_CYCLES  = 500;
   localparam int STALL_AFTER   = 120;
   localparam int PLAN_ROWS     = 22;
   localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;

   typedef struct packed {
      logic                  kind;
      logic [LEAF_BITS-1:0]  leaf;
      logic [VALUE_BITS-1:0] value;
      logic [LEAF_BITS-1:0]  lo;
      logic [LEAF_BITS-1:0]  hi;
      logic                  typed;
      logic [OUT_BITS-1:0]   typed_max;
   } plan_row_type;

   // typed_max is used only where typed is set
   localparam plan_row_type OPENING_PLAN [PLAN_ROWS] = '{
      '{KIND_QUERY,  10'd0,    32'h0,        10'd0,    10'd1023, 1'b1, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd1023, 10'd0,    1'b1, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd0,    10'd0,    1'b1, 32'h0},
      '{KIND_UPDATE, 10'd0,    32'hFFFFFFFF, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd0,    10'd0,    1'b1, 32'hFFFFFFFF},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd1,    10'd1023, 1'b1, 32'h0},
      '{KIND_UPDATE, 10'd1023, 32'h00000001, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd1023, 10'd1023, 1'b1, 32'h1},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd0,    10'd1023, 1'b1, 32'hFFFFFFFF},
      // lowering a leaf must pull its ancestors down
      '{KIND_UPDATE, 10'd0,    32'h0,        10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd0,    10'd1023, 1'b1, 32'h1},
      '{KIND_UPDATE, 10'd512,  32'hAAAAAAAA, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_UPDATE, 10'd511,  32'h55555555, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd511,  10'd512,  1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd1,    10'd1022, 1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd512,  10'd511,  1'b1, 32'h0},
      '{KIND_UPDATE, 10'd341,  32'h80000000, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_UPDATE, 10'd682,  32'h7FFFFFFF, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd341,  10'd682,  1'b0, 32'h0},
      '{KIND_UPDATE, 10'd512,  32'h00000002, 10'd0,    10'd0,    1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd0,    10'd1023, 1'b0, 32'h0},
      '{KIND_QUERY,  10'd0,    32'h0,        10'd682,  10'd1023, 1'b0, 32'h0}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   req_data_type req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [OUT_BITS-1:0] rsp_tdata;

   logic [VALUE_BITS-1:0] tree_nodes [NODE_COUNT];
   logic [OUT_BITS-1:0]   pending_max [$];
   int mismatch_count = 0;
   int answers_taken  = 0;
   int idle_cycles    = 0;
   int calm_run       = 0;

   range_max_segment_tree_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic void tree_set_leaf(input logic [LEAF_BITS-1:0] leaf,
                                         input logic [VALUE_BITS-1:0] value);
      int unsigned pos;
      pos = LEAVES + leaf;
      tree_nodes[pos] = value;
      while (pos > 1) begin
         pos = pos >> 1;
         tree_nodes[pos] = (tree_nodes[2*pos] > tree_nodes[2*pos+1]) ?
                           tree_nodes[2*pos] : tree_nodes[2*pos+1];
      end
   endfunction

   function automatic logic [OUT_BITS-1:0] tree_range_max(input logic [LEAF_BITS-1:0] lo,
                                                          input logic [LEAF_BITS-1:0] hi);
      int unsigned left;
      int unsigned right;
      logic [VALUE_BITS-1:0] best;
      best = '0;
      if (lo > hi) begin
         return '0;
      end
      // half-open node window, climbed one level per pass
      left  = LEAVES + lo;
      right = LEAVES + hi + 1;
      while (left < right) begin
         if (left[0]) begin
            if (tree_nodes[left] > best) best = tree_nodes[left];
            left++;
         end
         if (right[0]) begin
            right--;
            if (tree_nodes[right] > best) best = tree_nodes[right];
         end
         left  = left >> 1;
         right = right >> 1;
      end
      return best[OUT_BITS-1:0];
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm_run > 0) begin
         calm_run--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) begin
         calm_run = $urandom_range(30, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                  input logic [OUT_BITS-1:0] want);
      $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // drive one request and hold it until accepted, then predict its result
   task automatic send_request(input logic kind, input req_data_type payload,
                               input logic typed, input logic [OUT_BITS-1:0] typed_max,
                               input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_UPDATE) begin
         tree_set_leaf(payload.leaf_index, payload.new_value);
      end else begin
         pending_max.push_back(typed ? typed_max :
                               tree_range_max(payload.range_low, payload.range_high));
      end
   endtask

   initial begin : stimulus
      req_data_type payload;
      logic kind;
      int r;
      int hot_base;
      for (int n = 0; n < NODE_COUNT; n++) tree_nodes[n] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_PLAN[k]) begin
         payload = '0;
         payload.leaf_index = OPENING_PLAN[k].leaf;
         payload.new_value  = OPENING_PLAN[k].value;
         payload.range_low  = OPENING_PLAN[k].lo;
         payload.range_high = OPENING_PLAN[k].hi;
         send_request(OPENING_PLAN[k].kind, payload, OPENING_PLAN[k].typed,
                      OPENING_PLAN[k].typed_max, pick_gap());
      end

      hot_base = $urandom_range(0, LEAVES - 16);
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         // a moving window of busy leaves keeps queries hitting live values
         if (item % 64 == 0) hot_base = $urandom_range(0, LEAVES - 16);
         payload = '0;
         payload.leaf_index = LEAF_BITS'($urandom_range(0, LEAVES - 1));
         payload.new_value  = $urandom;
         payload.range_low  = LEAF_BITS'($urandom_range(0, LEAVES - 1));
         payload.range_high = LEAF_BITS'($urandom_range(0, LEAVES - 1));
         kind = ($urandom_range(99) < 50) ? KIND_UPDATE : KIND_QUERY;
         if (kind == KIND_UPDATE) begin
            if ($urandom_range(99) < 60) begin
               payload.leaf_index = LEAF_BITS'(hot_base + $urandom_range(0, 15));
            end
            r = $urandom_range(99);
            if (r < 10)      payload.new_value = '0;
            else if (r < 20) payload.new_value = ALL_ONES;
            else if (r < 40) payload.new_value = $urandom_range(0, 255);
         end else begin
            r = $urandom_range(99);
            if (r < 35) begin
               payload.range_low  = LEAF_BITS'(hot_base + $urandom_range(0, 7));
               payload.range_high = LEAF_BITS'(payload.range_low + $urandom_range(0, 15));
            end else if (r < 60) begin
               // fully random bounds, empty about half the time
            end else if (r < 70) begin
               payload.range_low  = '0;
               payload.range_high = LEAF_BITS'(LEAVES - 1);
            end else if (r < 80) begin
               payload.range_low  = LEAF_BITS'(hot_base + $urandom_range(0, 15));
               payload.range_high = payload.range_low;
            end else if (r < 90) begin
               payload.range_low  = LEAF_BITS'($urandom_range(1, LEAVES - 1));
               payload.range_high = LEAF_BITS'($urandom_range(0, payload.range_low - 1));
            end else if (r < 95) begin
               payload.range_high = LEAF_BITS'(LEAVES - 1);
            end else begin
               payload.range_low = '0;
            end
         end
         send_request(kind, payload, 1'b0, '0, pick_gap());
      end
      req_tvalid <= 1'b0;

      while (pending_max.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : rsp_side
      logic level;
      int hold;
      int r;
      bit stalled;
      stalled = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(99);
         if (!stalled && answers_taken >= STALL_AFTER) begin
            // long hold-off so the output register and the sequencer back up
            stalled = 1'b1;
            level = 1'b0;
            hold  = STALL_CYCLES;
         end else if (r < 50) begin
            level = 1'b1;
            hold  = $urandom_range(1, 6);
         end else if (r < 80) begin
            level = 1'b0;
            hold  = $urandom_range(1, 3);
         end else if (r < 92) begin
            level = 1'b1;
            hold  = $urandom_range(40, 150);
         end else begin
            level = 1'b0;
            hold  = $urandom_range(15, 60);
         end
         rsp_tready <= level;
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      logic [OUT_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_taken++;
         if (pending_max.size() == 0) begin
            report_mismatch("response with no query pending", rsp_tdata, '0);
         end else begin
            want = pending_max.pop_front();
            if (rsp_tdata !== want) report_mismatch("max_value", rsp_tdata, want);
         end
      end
   end

   // nothing accepted on either side for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/core/rmst_pkg.sv
rtl/core/range_max_segment_tree_top.sv
verif/tb_range_max_segment_tree_top.sv
